// File: sv/iedv_pkg.sv
package iedv_pkg;

    localparam int CHAR_WIDTH = 8;
    localparam int OUT_WIDTH  = 32;

    typedef logic [CHAR_WIDTH-1:0] t_char;
    typedef logic [OUT_WIDTH-1:0]  t_out_value;

    localparam t_char CH_EQ    = 8'h3D;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_STAR  = 8'h2A;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_0     = 8'h30;
    localparam t_char CH_9     = 8'h39;
    localparam t_char CH_SPACE = 8'h20;

    typedef logic [1:0] t_term_op;
    localparam t_term_op OP_NONE = 2'd0;
    localparam t_term_op OP_MUL  = 2'd1;
    localparam t_term_op OP_DIV  = 2'd2;

    typedef logic [2:0] t_kind;
    localparam t_kind K_SKIP  = 3'd0;
    localparam t_kind K_DIGIT = 3'd1;
    localparam t_kind K_MUL   = 3'd2;
    localparam t_kind K_DIV   = 3'd3;
    localparam t_kind K_ADD   = 3'd4;
    localparam t_kind K_SUB   = 3'd5;
    localparam t_kind K_EQ    = 3'd6;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_cmd;

    typedef struct packed {
        logic done;
        logic zero_div;
    } t_md_status;

    // Spaces have their own arm but map to K_SKIP, as does every unlisted character in the default arm.
    function automatic t_kind classify(input t_char c);
        t_kind k;
        case (c) inside
            [CH_0:CH_9]: k = K_DIGIT;
            CH_STAR:     k = K_MUL;
            CH_SLASH:    k = K_DIV;
            CH_PLUS:     k = K_ADD;
            CH_MINUS:    k = K_SUB;
            CH_EQ:       k = K_EQ;
            CH_SPACE:    k = K_SKIP;
            default:     k = K_SKIP;
        endcase
        return k;
    endfunction

endpackage

// File: sv/iedv_if.sv
interface iedv_char_if;
    logic                 valid;
    logic                 ready;
    iedv_pkg::t_char      character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface iedv_result_if;
    logic                 valid;
    logic                 ready;
    logic signed [iedv_pkg::OUT_WIDTH-1:0] value;
    logic                 divide_by_zero;

    modport source (output valid, output value, output divide_by_zero, input ready);
    modport sink   (input valid, input value, input divide_by_zero, output ready);
endinterface

// File: sv/iedv_muldiv.sv
module iedv_muldiv #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  iedv_pkg::t_md_cmd      i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output iedv_pkg::t_md_status   o_status,
    output logic [VALUE_WIDTH-1:0] o_result
);
    import iedv_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   r_busy;
    logic                   r_done;
    logic                   r_dz;
    logic                   r_div;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH-1:0] r_b;

    logic [VALUE_WIDTH-1:0] w_mag_a;
    logic [VALUE_WIDTH-1:0] w_mag_b;
    logic [VALUE_WIDTH:0]   w_rem_sh;
    logic [VALUE_WIDTH:0]   w_diff;
    logic                   w_qbit;

    assign w_mag_a  = i_a[VALUE_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b  = i_b[VALUE_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_rem_sh = {r_acc, r_a[VALUE_WIDTH-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_b};
    assign w_qbit   = ~w_diff[VALUE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_dz   <= 1'b0;
            r_div  <= 1'b0;
            r_neg  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_div <= i_cmd.is_div;
                r_acc <= '0;
                r_cnt <= CW'(VALUE_WIDTH - 1);
                r_dz  <= 1'b0;
                if (i_cmd.is_div) begin
                    if (i_b == '0) begin
                        // A zero divisor finishes at once with a zero quotient.
                        r_a    <= '0;
                        r_neg  <= 1'b0;
                        r_dz   <= 1'b1;
                        r_done <= 1'b1;
                    end else begin
                        r_a    <= w_mag_a;
                        r_b    <= w_mag_b;
                        r_neg  <= i_a[VALUE_WIDTH-1] ^ i_b[VALUE_WIDTH-1];
                        r_busy <= 1'b1;
                    end
                end else begin
                    r_a    <= i_a;
                    r_b    <= i_b;
                    r_neg  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_div) begin
                    r_acc <= w_qbit ? w_diff[VALUE_WIDTH-1:0] : w_rem_sh[VALUE_WIDTH-1:0];
                    r_a   <= {r_a[VALUE_WIDTH-2:0], w_qbit};
                end else begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= {r_a[VALUE_WIDTH-2:0], 1'b0};
                    r_b <= {1'b0, r_b[VALUE_WIDTH-1:1]};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (!r_div) begin
            o_result = r_acc;
        end else if (r_neg) begin
            o_result = ~r_a + 1'b1;
        end else begin
            o_result = r_a;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.zero_div = r_dz;

endmodule

// File: sv/infix_integer_expression_evaluator_core.sv
// Digits and ignored characters are taken in the idle state, which the core does not leave.
// An operator or '=' with no pending multiply or divide goes from idle to the fold state and back.
// An operator or '=' that closes a multiply or divide passes through the busy state first, while
// the shared shift-and-add / restoring-division unit works; a zero divisor ends that unit's work at once.
// One character at a time; '=' also waits while an earlier result is not yet taken.
// Synchronous active-low reset clears all evaluator state and the output register.
module infix_integer_expression_evaluator_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iedv_char_if.sink     i_char,
    iedv_result_if.source o_result
);
    import iedv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0]             r_state;
    t_kind                  r_kind;
    logic [VALUE_WIDTH-1:0] r_num;
    logic [VALUE_WIDTH-1:0] r_term;
    logic [VALUE_WIDTH-1:0] r_sum;
    logic                   r_sub;
    t_term_op               r_pend_op;
    logic                   r_zero_seen;
    logic                   r_out_valid;
    t_out_value             r_out_value;
    logic                   r_out_dz;

    logic                   w_accept;
    t_kind                  w_kind;
    logic [VALUE_WIDTH-1:0] w_num_digit;
    logic [VALUE_WIDTH-1:0] n_sum;
    t_out_value             w_sum_ext;
    logic                   w_out_load;
    t_md_cmd                s_md_cmd;
    t_md_status             s_md_status;
    logic [VALUE_WIDTH-1:0] w_md_result;

    assign i_char.ready = (r_state == ST_IDLE);
    assign w_accept     = i_char.valid && i_char.ready;
    assign w_kind       = classify(i_char.character);

    assign w_num_digit = {r_num[VALUE_WIDTH-4:0], 3'b000} + {r_num[VALUE_WIDTH-2:0], 1'b0}
                       + {{(VALUE_WIDTH-4){1'b0}}, i_char.character[3:0]};

    assign n_sum = r_sub ? (r_sum - r_term) : (r_sum + r_term);

    generate
        if (VALUE_WIDTH >= OUT_WIDTH) begin : g_trunc
            assign w_sum_ext = n_sum[OUT_WIDTH-1:0];
        end else begin : g_sext
            assign w_sum_ext = {{(OUT_WIDTH-VALUE_WIDTH){n_sum[VALUE_WIDTH-1]}}, n_sum};
        end
    endgenerate

    assign s_md_cmd.start  = w_accept && (w_kind != K_DIGIT) && (w_kind != K_SKIP)
                          && (r_pend_op != OP_NONE);
    assign s_md_cmd.is_div = (r_pend_op == OP_DIV);

    assign w_out_load = (r_state == ST_FOLD) && (r_kind == K_EQ)
                     && (!r_out_valid || o_result.ready);

    iedv_muldiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (s_md_cmd),
        .i_a      (r_term),
        .i_b      (r_num),
        .o_status (s_md_status),
        .o_result (w_md_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= K_SKIP;
            r_num       <= '0;
            r_term      <= '0;
            r_sum       <= '0;
            r_sub       <= 1'b0;
            r_pend_op   <= OP_NONE;
            r_zero_seen <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_out_dz    <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_kind == K_DIGIT) begin
                            r_num <= w_num_digit;
                        end else if (w_kind != K_SKIP) begin
                            r_kind <= w_kind;
                            if (r_pend_op != OP_NONE) begin
                                r_state <= ST_BUSY;
                            end else begin
                                r_term  <= r_num;
                                r_num   <= '0;
                                r_state <= ST_FOLD;
                            end
                        end
                    end
                end
                ST_BUSY: begin
                    if (s_md_status.done) begin
                        r_term      <= w_md_result;
                        r_zero_seen <= r_zero_seen | s_md_status.zero_div;
                        r_num       <= '0;
                        r_state     <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    case (r_kind) inside
                        K_MUL: begin
                            r_pend_op <= OP_MUL;
                            r_state   <= ST_IDLE;
                        end
                        K_DIV: begin
                            r_pend_op <= OP_DIV;
                            r_state   <= ST_IDLE;
                        end
                        K_ADD, K_SUB: begin
                            r_sum     <= n_sum;
                            r_term    <= '0;
                            r_pend_op <= OP_NONE;
                            r_sub     <= (r_kind == K_SUB);
                            r_state   <= ST_IDLE;
                        end
                        K_EQ: begin
                            if (w_out_load) begin
                                r_out_value <= w_sum_ext;
                                r_out_dz    <= r_zero_seen;
                                r_num       <= '0;
                                r_term      <= '0;
                                r_sum       <= '0;
                                r_sub       <= 1'b0;
                                r_pend_op   <= OP_NONE;
                                r_zero_seen <= 1'b0;
                                r_state     <= ST_IDLE;
                            end
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.value          = r_out_value;
    assign o_result.divide_by_zero = r_out_dz;

    a_done_only_when_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_md_status.done |-> (r_state == ST_BUSY)
    ) else $error("Arithmetic unit finished outside the busy state.");

    a_done_then_fold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_md_status.done |=> (r_state == ST_FOLD) && (r_num == '0)
    ) else $error("Finished operation did not move to the fold state.");

    a_state_cleared_after_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_sum == '0) && (r_term == '0) && (r_num == '0)
                       && !r_zero_seen && (r_pend_op == OP_NONE) && r_out_valid
    ) else $error("Evaluator state not cleared after a result transfer was loaded.");

endmodule

// File: tb/tb.sv
module tb;
    import iedv_pkg::*;

    localparam int VW = 32;

    typedef struct packed {
        t_out_value value;
        logic       divide_by_zero;
    } t_expr_result;

    // Tracks the evaluator's state for every accepted character and holds the
    // results of completed expressions until the block delivers them.
    class expr_scoreboard;
        logic [VW-1:0]  number_acc;
        logic [VW-1:0]  term_acc;
        logic [VW-1:0]  sum_acc;
        bit             subtract_next;
        t_term_op       term_op;
        bit             zero_div_seen;
        t_expr_result   expected_q[$];
        int             mismatches;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            number_acc    = '0;
            term_acc      = '0;
            sum_acc       = '0;
            subtract_next = 1'b0;
            term_op       = OP_NONE;
            zero_div_seen = 1'b0;
        endfunction

        function logic [VW-1:0] quotient(logic [VW-1:0] a, logic [VW-1:0] b);
            logic [VW-1:0] mag_a;
            logic [VW-1:0] mag_b;
            logic [VW-1:0] q;
            mag_a = a[VW-1] ? -a : a;
            mag_b = b[VW-1] ? -b : b;
            q = mag_a / mag_b;
            return (a[VW-1] ^ b[VW-1]) ? -q : q;
        endfunction

        function void fold_number();
            if (term_op == OP_MUL) begin
                term_acc = term_acc * number_acc;
            end else if (term_op == OP_DIV) begin
                if (number_acc == '0) begin
                    zero_div_seen = 1'b1;
                    term_acc = '0;
                end else begin
                    term_acc = quotient(term_acc, number_acc);
                end
            end else begin
                term_acc = number_acc;
            end
            number_acc = '0;
        endfunction

        function void fold_term();
            if (subtract_next) begin
                sum_acc = sum_acc - term_acc;
            end else begin
                sum_acc = sum_acc + term_acc;
            end
            term_acc = '0;
            term_op = OP_NONE;
        endfunction

        function void note_char(t_char c);
            t_expr_result r;
            if (c >= CH_0 && c <= CH_9) begin
                number_acc = number_acc * 10 + VW'(c - CH_0);
            end else if (c == CH_STAR || c == CH_SLASH) begin
                fold_number();
                term_op = (c == CH_STAR) ? OP_MUL : OP_DIV;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                fold_number();
                fold_term();
                subtract_next = (c == CH_MINUS);
            end else if (c == CH_EQ) begin
                fold_number();
                fold_term();
                r.value = t_out_value'($signed(sum_acc));
                r.divide_by_zero = zero_div_seen;
                expected_q.push_back(r);
                clear_state();
            end
        endfunction

        function void check_result(t_out_value value, logic divide_by_zero);
            t_expr_result e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: value %0d divide_by_zero %0b",
                             $signed(value), divide_by_zero);
                end
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value || divide_by_zero !== e.divide_by_zero) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"result mismatch: expected value %0d divide_by_zero %0b, ",
                              "got value %0d divide_by_zero %0b"},
                             $signed(e.value), e.divide_by_zero,
                             $signed(value), divide_by_zero);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   chars_sent;

    iedv_char_if   char_bus ();
    iedv_result_if result_bus ();

    expr_scoreboard sb = new();

    infix_integer_expression_evaluator_core #(
        .VALUE_WIDTH(VW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_result(result_bus)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        result_bus.ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                sb.check_result(result_bus.value, result_bus.divide_by_zero);
            end
            if (char_bus.valid && char_bus.ready) begin
                sb.note_char(char_bus.character);
            end
        end
    end

    task automatic send_char(input t_char c);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 14) begin
            char_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.character <= c;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        chars_sent++;
        calm = (chars_sent >= 700 && chars_sent < 1000);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(t_char'(s[i]));
        end
    endtask

    task automatic send_number();
        int unsigned      pick;
        longint unsigned  v;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return;
        end else if (pick < 60) begin
            v = $urandom_range(0, 99);
        end else if (pick < 78) begin
            v = $urandom_range(0, 9999);
        end else if (pick < 88) begin
            v = $urandom;
        end else if (pick < 92) begin
            v = {$urandom, $urandom};
        end else begin
            case ($urandom_range(0, 3))
                0: v = 64'd2147483648;
                1: v = 64'd4294967295;
                2: v = 64'd2147483647;
                default: v = 64'd65536;
            endcase
        end
        send_text($sformatf("%0d", v));
    endtask

    task automatic send_operator();
        if ($urandom_range(0, 9) == 0) begin
            send_char(CH_SPACE);
        end
        if ($urandom_range(0, 29) == 0) begin
            send_char(t_char'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 3))
            0: send_char(CH_PLUS);
            1: send_char(CH_MINUS);
            2: send_char(CH_STAR);
            default: send_char(CH_SLASH);
        endcase
    endtask

    task automatic send_expression();
        int unsigned terms;
        int unsigned noise_len;
        if ($urandom_range(0, 9) == 0) begin
            noise_len = $urandom_range(1, 10);
            repeat (noise_len) send_char(t_char'($urandom_range(0, 255)));
        end else begin
            terms = $urandom_range(1, 6);
            for (int unsigned t = 0; t < terms; t++) begin
                if (t > 0 || $urandom_range(0, 9) == 0) begin
                    send_operator();
                end
                send_number();
            end
        end
        send_char(CH_EQ);
    endtask

    initial begin
        i_rst_n = 1'b0;
        calm = 1'b0;
        chars_sent = 0;
        char_bus.valid = 1'b0;
        char_bus.character = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_text("=");
        send_char(8'h00);
        send_text("7");
        send_char(8'hFF);
        send_text("/0=");
        send_text("-9*3+8/2 1=");
        send_text("*/=");

        while (chars_sent < 1800) begin
            send_expression();
        end

        @(negedge i_clk);
        char_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (VW + 8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/iedv_pkg.sv
sv/iedv_if.sv
sv/iedv_muldiv.sv
sv/infix_integer_expression_evaluator_core.sv
tb/tb.sv
